FILE: design/mbd_pkg.sv
// ============================================================================
// mbd_pkg : mipmap box downsample shared definitions
// Widths, defaults, register indexes and control bundles for the block.
// ============================================================================
package mbd_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NUM_LANES       = 4;
    localparam int FIELD_W         = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int SRC_WIDTH_W     = 13;
    localparam int SRC_HEIGHT_W    = 16;
    localparam int CHAN_CNT_W      = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_WIDTH     = 2'd0,
        CFG_SRC_HEIGHT    = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic w2;
        logic h2;
    } t_lane_mode;

    typedef struct packed {
        logic eor;
        logic last;
    } t_flags;

    typedef struct packed {
        logic [NUM_LANES-1:0] chan_en;
        t_lane_mode           mode;
        logic                 done;
        t_flags               flags;
    } t_ctl;

endpackage

FILE: design/mbd_ram.sv
// ============================================================================
// mbd_ram : generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module mbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mbd_lane.sv
// ============================================================================
// mbd_lane : per-channel 2x2 box average
// Sums the samples of one channel that the block shape needs and shifts
// the sum right by log2 of their count.
// ============================================================================
module mbd_lane #(
    parameter int SAMPLE_BITS = mbd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_chan_en,
    input  mbd_pkg::t_lane_mode    i_mode,
    input  logic [SAMPLE_BITS-1:0] i_cur,
    input  logic [SAMPLE_BITS-1:0] i_prev,
    input  logic [SAMPLE_BITS-1:0] i_above,
    input  logic [SAMPLE_BITS-1:0] i_above_last,
    output logic [SAMPLE_BITS-1:0] o_avg
);

    localparam int SUM_W = SAMPLE_BITS + 2;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] shifted;
    logic [1:0]       sh;

    always_comb begin
        sum = SUM_W'(i_cur);
        if (i_mode.w2) begin
            sum = sum + SUM_W'(i_prev);
        end
        if (i_mode.h2) begin
            sum = sum + SUM_W'(i_above);
            if (i_mode.w2) begin
                sum = sum + SUM_W'(i_above_last);
            end
        end
        sh      = 2'(i_mode.w2) + 2'(i_mode.h2);
        shifted = sum >> sh;
        o_avg   = i_chan_en ? shifted[SAMPLE_BITS-1:0] : '0;
    end

endmodule

FILE: design/mbd_merge.sv
// ============================================================================
// mbd_merge : result assembly and output register
// Combines the lane averages with the row and image flags into one result
// item and holds it until the downstream side takes it.
// ============================================================================
module mbd_merge #(
    parameter int SAMPLE_BITS = mbd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_push,
    input  logic [mbd_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] i_avg,
    input  mbd_pkg::t_flags                               i_flags,
    input  logic                                          i_stall,
    output logic                                          o_free,
    output logic                                          o_valid,
    output logic [mbd_pkg::FIELD_W-1:0]                   o_ch0,
    output logic [mbd_pkg::FIELD_W-1:0]                   o_ch1,
    output logic [mbd_pkg::FIELD_W-1:0]                   o_ch2,
    output logic [mbd_pkg::FIELD_W-1:0]                   o_ch3,
    output logic                                          o_end_of_row,
    output logic                                          o_last_of_image
);

    logic                                          r_valid;
    logic [mbd_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] r_avg;
    mbd_pkg::t_flags                               r_flags;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_avg   <= i_avg;
            r_flags <= i_flags;
        end
    end

    assign o_valid         = r_valid;
    assign o_ch0           = mbd_pkg::FIELD_W'(r_avg[0]);
    assign o_ch1           = mbd_pkg::FIELD_W'(r_avg[1]);
    assign o_ch2           = mbd_pkg::FIELD_W'(r_avg[2]);
    assign o_ch3           = mbd_pkg::FIELD_W'(r_avg[3]);
    assign o_end_of_row    = r_flags.eor;
    assign o_last_of_image = r_flags.last;

endmodule

FILE: design/mipmap_box_downsample.sv
// ============================================================================
// mipmap_box_downsample : one 2x2 box-filter mipmap level
// Takes source pixels in raster order and emits the average of each
// complete 2x2 block, one channel per lane, with row and image end flags.
// ============================================================================
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_ch0..i_in_ch3
//  out       output     o_out_valid / i_out_stall o_out_ch0..3, end_of_row,
//                                                 last_of_image
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One pixel per clock sustained while the output is not stalled; each item
//  passes through two register stages (row RAM read with lane operands,
//  output register) before its result is offered.
//  The single-port-read row RAM sets the pace: one read per pixel.
//  Synchronous active-low reset clears position, previous pixel and valids.
//  A stalled output holds a result-bearing item in the lane stage, which then
//  stalls the input.
// ============================================================================
module mipmap_box_downsample #(
    parameter int MAX_WIDTH   = mbd_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = mbd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mbd_pkg::FIELD_W-1:0]       i_in_ch0,
    input  logic [mbd_pkg::FIELD_W-1:0]       i_in_ch1,
    input  logic [mbd_pkg::FIELD_W-1:0]       i_in_ch2,
    input  logic [mbd_pkg::FIELD_W-1:0]       i_in_ch3,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mbd_pkg::FIELD_W-1:0]       o_out_ch0,
    output logic [mbd_pkg::FIELD_W-1:0]       o_out_ch1,
    output logic [mbd_pkg::FIELD_W-1:0]       o_out_ch2,
    output logic [mbd_pkg::FIELD_W-1:0]       o_out_ch3,
    output logic                              o_out_end_of_row,
    output logic                              o_out_last_of_image,
    input  logic                              i_cfg_we,
    input  logic [mbd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = XW + 1;
    localparam int HW    = mbd_pkg::SRC_HEIGHT_W;
    localparam int NL    = mbd_pkg::NUM_LANES;
    localparam int PIX_W = NL * SAMPLE_BITS;

    logic [mbd_pkg::SRC_WIDTH_W-1:0]  r_src_width;
    logic [mbd_pkg::SRC_HEIGHT_W-1:0] r_src_height;
    logic [mbd_pkg::CHAN_CNT_W-1:0]   r_channel_count;

    logic [XW-1:0]    r_col;
    logic [HW-1:0]    r_row;
    logic [PIX_W-1:0] r_prev;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_cur;
    logic [PIX_W-1:0] r_s1_prev;
    mbd_pkg::t_ctl    r_s1_ctl;
    logic [PIX_W-1:0] r_above_last;

    logic                               cfg_hit;
    logic [31:0]                        w_ext;
    logic [WW-1:0]                      w;
    logic [WW-1:0]                      w_even;
    logic [WW-1:0]                      x_ext;
    logic [HW-1:0]                      h;
    logic [HW-1:0]                      h_even;
    logic [mbd_pkg::CHAN_CNT_W-1:0]     n;
    logic [PIX_W-1:0]                   cur;
    logic [mbd_pkg::FIELD_W-1:0]        in_ch [NL];
    mbd_pkg::t_ctl                      ctl;
    logic                               in_acc;
    logic                               s1_adv;
    logic                               out_free;
    logic [PIX_W-1:0]                   above;
    logic [NL-1:0][SAMPLE_BITS-1:0]     avg;

    // configuration registers
    always_comb begin
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbd_pkg::CFG_SRC_WIDTH:     cfg_hit = 1'b1;
                mbd_pkg::CFG_SRC_HEIGHT:    cfg_hit = 1'b1;
                mbd_pkg::CFG_CHANNEL_COUNT: cfg_hit = 1'b1;
                default:                    cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width     <= mbd_pkg::SRC_WIDTH_W'(1);
            r_src_height    <= mbd_pkg::SRC_HEIGHT_W'(1);
            r_channel_count <= mbd_pkg::CHAN_CNT_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbd_pkg::CFG_SRC_WIDTH:
                    r_src_width <= i_cfg_data[mbd_pkg::SRC_WIDTH_W-1:0];
                mbd_pkg::CFG_SRC_HEIGHT:
                    r_src_height <= i_cfg_data[mbd_pkg::SRC_HEIGHT_W-1:0];
                mbd_pkg::CFG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[mbd_pkg::CHAN_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry and per-pixel decisions
    assign in_ch[0] = i_in_ch0;
    assign in_ch[1] = i_in_ch1;
    assign in_ch[2] = i_in_ch2;
    assign in_ch[3] = i_in_ch3;

    always_comb begin
        w_ext = 32'(r_src_width);
        if (w_ext == 32'd0) begin
            w = WW'(1);
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(w_ext);
        end
        h = (r_src_height == '0) ? HW'(1) : r_src_height;
        if (r_channel_count == '0) begin
            n = mbd_pkg::CHAN_CNT_W'(1);
        end else if (r_channel_count > mbd_pkg::CHAN_CNT_W'(NL)) begin
            n = mbd_pkg::CHAN_CNT_W'(NL);
        end else begin
            n = r_channel_count;
        end
        w_even = {w[WW-1:1], 1'b0};
        h_even = {h[HW-1:1], 1'b0};
        x_ext  = WW'(r_col);

        for (int c = 0; c < NL; c++) begin
            ctl.chan_en[c] = (mbd_pkg::CHAN_CNT_W'(c) < n);
            cur[c*SAMPLE_BITS +: SAMPLE_BITS] =
                ctl.chan_en[c] ? in_ch[c][SAMPLE_BITS-1:0] : '0;
        end

        ctl.mode.w2 = (w >= WW'(2));
        ctl.mode.h2 = (h >= HW'(2));
        ctl.done = (ctl.mode.w2 ? (r_col[0] && (x_ext < w_even)) : 1'b1)
                && (ctl.mode.h2 ? (r_row[0] && (r_row < h_even)) : 1'b1);
        ctl.flags.eor  = ctl.mode.w2 ? ((x_ext + WW'(1)) == w_even) : 1'b1;
        ctl.flags.last = ctl.flags.eor
                && (ctl.mode.h2 ? ((r_row + HW'(1)) == h_even) : 1'b1);
    end

    assign s1_adv     = r_s1_valid && (!r_s1_ctl.done || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // source position and previous pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_prev <= cur;
            if ((x_ext + WW'(1)) == w) begin
                r_col <= '0;
                r_row <= ((r_row + HW'(1)) == h) ? '0 : r_row + HW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    // row store: written on even rows, read at every pixel
    mbd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata (cur),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    // lane stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cur  <= cur;
            r_s1_prev <= r_prev;
            r_s1_ctl  <= ctl;
        end
        if (s1_adv) begin
            r_above_last <= above;
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        mbd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_chan_en    (r_s1_ctl.chan_en[g]),
            .i_mode       (r_s1_ctl.mode),
            .i_cur        (r_s1_cur[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_prev       (r_s1_prev[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_above      (above[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_above_last (r_above_last[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_avg        (avg[g])
        );
    end

    mbd_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (s1_adv && r_s1_ctl.done),
        .i_avg           (avg),
        .i_flags         (r_s1_ctl.flags),
        .i_stall         (i_out_stall),
        .o_free          (out_free),
        .o_valid         (o_out_valid),
        .o_ch0           (o_out_ch0),
        .o_ch1           (o_out_ch1),
        .o_ch2           (o_out_ch2),
        .o_ch3           (o_out_ch3),
        .o_end_of_row    (o_out_end_of_row),
        .o_last_of_image (o_out_last_of_image)
    );

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_ext < w)
        else $error("source column beyond effective width");

    a_last_has_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_end_of_row || !o_out_last_of_image))
        else $error("last_of_image without end_of_row");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item missing from lane stage");

    a_blocked_result_stalls: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.done && !out_free) |-> o_in_stall)
        else $error("input taken while result is blocked");

endmodule

FILE: sim/mipmap_box_downsample_tb.sv
// ============================================================================
// mipmap_box_downsample_tb : self-checking bench for the 2x2 box downsampler
// Streams source pixels through the block under a series of geometries and
// channel counts, predicts every averaged pixel and its row/image flags, and
// compares each output item against the oldest prediction. Both handshakes
// idle at random, with one calm stretch and one long output hold-off.
// ============================================================================
module mipmap_box_downsample_tb;

    typedef struct packed {
        logic [mbd_pkg::FIELD_W-1:0] c3;
        logic [mbd_pkg::FIELD_W-1:0] c2;
        logic [mbd_pkg::FIELD_W-1:0] c1;
        logic [mbd_pkg::FIELD_W-1:0] c0;
    } t_pixel;

    typedef struct packed {
        logic [mbd_pkg::FIELD_W-1:0] c3;
        logic [mbd_pkg::FIELD_W-1:0] c2;
        logic [mbd_pkg::FIELD_W-1:0] c1;
        logic [mbd_pkg::FIELD_W-1:0] c0;
        logic                        eor;
        logic                        last;
    } t_avg;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [mbd_pkg::FIELD_W-1:0]     i_in_ch0 = '0;
    logic [mbd_pkg::FIELD_W-1:0]     i_in_ch1 = '0;
    logic [mbd_pkg::FIELD_W-1:0]     i_in_ch2 = '0;
    logic [mbd_pkg::FIELD_W-1:0]     i_in_ch3 = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [mbd_pkg::FIELD_W-1:0]     o_out_ch0;
    logic [mbd_pkg::FIELD_W-1:0]     o_out_ch1;
    logic [mbd_pkg::FIELD_W-1:0]     o_out_ch2;
    logic [mbd_pkg::FIELD_W-1:0]     o_out_ch3;
    logic                            o_out_end_of_row;
    logic                            o_out_last_of_image;
    logic                            i_cfg_we = 1'b0;
    logic [mbd_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [mbd_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    mipmap_box_downsample u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_ch0            (i_in_ch0),
        .i_in_ch1            (i_in_ch1),
        .i_in_ch2            (i_in_ch2),
        .i_in_ch3            (i_in_ch3),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_ch0           (o_out_ch0),
        .o_out_ch1           (o_out_ch1),
        .o_out_ch2           (o_out_ch2),
        .o_out_ch3           (o_out_ch3),
        .o_out_end_of_row    (o_out_end_of_row),
        .o_out_last_of_image (o_out_last_of_image),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [mbd_pkg::SRC_WIDTH_W-1:0]  geo_width = 13'd1;
    logic [mbd_pkg::SRC_HEIGHT_W-1:0] geo_height = 16'd1;
    logic [mbd_pkg::CHAN_CNT_W-1:0]   geo_chans = 3'd4;
    logic [63:0]                      row_mem [mbd_pkg::MAX_WIDTH_DEF];
    logic [63:0]                      prev_px = '0;
    int unsigned                      col_pos = 0;
    int unsigned                      row_pos = 0;

    t_pixel      src_pixels [$];
    t_avg        pending_avgs [$];
    t_pixel      next_px;
    t_avg        mon_want;
    t_avg        mon_got;
    t_avg        mon_pred;
    int unsigned errors = 0;
    int unsigned n_in = 0;
    int unsigned n_out = 0;
    int unsigned n_phases = 0;
    int unsigned hold_cnt = 0;
    logic        hold_armed = 1'b1;
    logic        hold_req = 1'b0;
    logic        calm = 1'b0;
    int unsigned gw = 1;
    int unsigned gh = 1;
    int unsigned gc = 4;

    function automatic bit box_average_step(input t_pixel px, output t_avg res);
        int unsigned w, h, n, dw, dh, x, y, dx, dy, sh, c;
        logic [17:0] s;
        logic [63:0] raw, cur;
        logic [mbd_pkg::FIELD_W-1:0] lane [4];
        bit done_x, done_y;
        w = (geo_width == 0) ? 1 : geo_width;
        if (w > mbd_pkg::MAX_WIDTH_DEF) w = mbd_pkg::MAX_WIDTH_DEF;
        h = (geo_height == 0) ? 1 : geo_height;
        n = (geo_chans == 0) ? 1 : (geo_chans > 4) ? 4 : geo_chans;
        dw = (w >= 2) ? w / 2 : 1;
        dh = (h >= 2) ? h / 2 : 1;
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        raw = px;
        cur = '0;
        for (c = 0; c < n; c++) cur[16*c +: 16] = raw[16*c +: 16];
        done_x = (w >= 2) ? ((x % 2 == 1) && x < 2 * dw) : (x == 0);
        done_y = (h >= 2) ? ((y % 2 == 1) && y < 2 * dh) : (y == 0);
        res = '0;
        if (done_x && done_y) begin
            dx = (w >= 2) ? x / 2 : 0;
            dy = (h >= 2) ? y / 2 : 0;
            for (c = 0; c < 4; c++) begin
                s = '0;
                sh = 0;
                if (c < n) begin
                    s = 18'(cur[16*c +: 16]);
                    if (w >= 2) begin
                        s = s + 18'(prev_px[16*c +: 16]);
                        sh++;
                    end
                    if (h >= 2) begin
                        s = s + 18'(row_mem[x][16*c +: 16]);
                        sh++;
                        if (w >= 2) s = s + 18'(row_mem[x-1][16*c +: 16]);
                    end
                    s = s >> sh;
                end
                lane[c] = s[15:0];
            end
            res.c0 = lane[0];
            res.c1 = lane[1];
            res.c2 = lane[2];
            res.c3 = lane[3];
            res.eor = (dx == dw - 1);
            res.last = (dx == dw - 1) && (dy == dh - 1);
        end
        if (y % 2 == 0) row_mem[x] = cur;
        prev_px = cur;
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
        return done_x && done_y;
    endfunction

    // check outputs, then predict from accepted inputs and register writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_out++;
                mon_got = {o_out_ch3, o_out_ch2, o_out_ch1, o_out_ch0,
                           o_out_end_of_row, o_out_last_of_image};
                if (pending_avgs.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected output item: ch %h %h %h %h eor %b last %b",
                                 mon_got.c0, mon_got.c1, mon_got.c2, mon_got.c3,
                                 mon_got.eor, mon_got.last);
                    errors++;
                end else begin
                    mon_want = pending_avgs.pop_front();
                    if (mon_got.c0 !== mon_want.c0 || mon_got.c1 !== mon_want.c1 ||
                        mon_got.c2 !== mon_want.c2 || mon_got.c3 !== mon_want.c3 ||
                        mon_got.eor !== mon_want.eor || mon_got.last !== mon_want.last) begin
                        if (errors < 10) begin
                            $display("mismatch at output %0d: exp ch %h %h %h %h eor %b last %b",
                                     n_out, mon_want.c0, mon_want.c1, mon_want.c2,
                                     mon_want.c3, mon_want.eor, mon_want.last);
                            $display("    got ch %h %h %h %h eor %b last %b",
                                     mon_got.c0, mon_got.c1, mon_got.c2, mon_got.c3,
                                     mon_got.eor, mon_got.last);
                        end
                        errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mbd_pkg::CFG_SRC_WIDTH: begin
                        geo_width = i_cfg_data[mbd_pkg::SRC_WIDTH_W-1:0];
                        col_pos = 0;
                        row_pos = 0;
                    end
                    mbd_pkg::CFG_SRC_HEIGHT: begin
                        geo_height = i_cfg_data[mbd_pkg::SRC_HEIGHT_W-1:0];
                        col_pos = 0;
                        row_pos = 0;
                    end
                    mbd_pkg::CFG_CHANNEL_COUNT: begin
                        geo_chans = i_cfg_data[mbd_pkg::CHAN_CNT_W-1:0];
                        col_pos = 0;
                        row_pos = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                n_in++;
                if (box_average_step({i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0}, mon_pred))
                    pending_avgs.push_back(mon_pred);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (src_pixels.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
                next_px = src_pixels.pop_front();
                i_in_valid <= 1'b1;
                i_in_ch0 <= next_px.c0;
                i_in_ch1 <= next_px.c1;
                i_in_ch2 <= next_px.c2;
                i_in_ch3 <= next_px.c3;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cnt != 0) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_armed && hold_req) begin
            i_out_stall <= 1'b1;
            hold_cnt <= 400;
            hold_armed <= 1'b0;
        end else begin
            i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
        end
    end

    task automatic write_reg(mbd_pkg::t_cfg_idx idx, logic [mbd_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned c);
        gw = w;
        gh = h;
        gc = c;
        write_reg(mbd_pkg::CFG_SRC_WIDTH, mbd_pkg::CFG_DATA_W'(w));
        write_reg(mbd_pkg::CFG_SRC_HEIGHT, mbd_pkg::CFG_DATA_W'(h));
        write_reg(mbd_pkg::CFG_CHANNEL_COUNT, mbd_pkg::CFG_DATA_W'(c));
        n_phases++;
    endtask

    task automatic push_pixel(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [15:0] d);
        t_pixel px;
        px.c0 = a;
        px.c1 = b;
        px.c2 = c;
        px.c3 = d;
        src_pixels.push_back(px);
    endtask

    task automatic push_random(int unsigned count);
        t_pixel px;
        repeat (count) begin
            px = {$urandom(), $urandom()};
            src_pixels.push_back(px);
        end
    endtask

    // hold the sender until every prediction is matched, then let the pipe drain
    task automatic settle();
        while (src_pixels.size() != 0 || i_in_valid || pending_avgs.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int unsigned rand_items, ew, eh, fsize, cnt, frames, r;
        logic [2:0] mask;
        rand_items = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        settle();

        set_geometry(2, 2, 4);
        repeat (4) push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0000);
        push_pixel(16'h0000, 16'h0001, 16'h0000, 16'h0003);
        push_pixel(16'h0001, 16'h0000, 16'h0003, 16'h0000);
        push_pixel(16'h0001, 16'h0000, 16'h0003, 16'h0000);
        settle();

        set_geometry(0, 0, 0);
        repeat (2) push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        set_geometry(3, 1, 7);
        push_random(3);
        settle();

        set_geometry(1, 3, 2);
        push_random(3);
        settle();

        set_geometry(8191, 1, 4);
        push_random(256);
        settle();

        set_geometry(4096, 65535, 4);
        push_random(200);
        settle();

        set_geometry(1, 65535, 3);
        push_random(120);
        settle();

        set_geometry(2, 1, 4);
        hold_req <= 1'b1;
        push_random(200);
        settle();

        calm <= 1'b1;
        set_geometry(6, 4, 4);
        push_random(72);
        settle();
        calm <= 1'b0;

        while (rand_items < 550) begin
            mask = 3'($urandom_range(0, 7));
            if (mask[0]) begin
                r = $urandom_range(0, 9);
                gw = (r == 0) ? $urandom_range(13, 64) : (r == 1) ? 0 : $urandom_range(1, 12);
                write_reg(mbd_pkg::CFG_SRC_WIDTH, mbd_pkg::CFG_DATA_W'(gw));
            end
            if (mask[1]) begin
                gh = (gw > 12) ? $urandom_range(0, 4) : $urandom_range(0, 9);
                write_reg(mbd_pkg::CFG_SRC_HEIGHT, mbd_pkg::CFG_DATA_W'(gh));
            end
            if (mask[2]) begin
                gc = $urandom_range(0, 7);
                write_reg(mbd_pkg::CFG_CHANNEL_COUNT, mbd_pkg::CFG_DATA_W'(gc));
            end
            ew = (gw == 0) ? 1 : (gw > mbd_pkg::MAX_WIDTH_DEF) ? mbd_pkg::MAX_WIDTH_DEF : gw;
            eh = (gh == 0) ? 1 : gh;
            fsize = ew * eh;
            if (mask == 0) begin
                cnt = $urandom_range(1, 40);
            end else begin
                n_phases++;
                frames = (fsize > 150) ? 1 : $urandom_range(1, 3);
                cnt = frames * fsize;
                if ($urandom_range(0, 2) == 0 && fsize > 1) cnt += $urandom_range(1, fsize - 1);
            end
            push_random(cnt);
            rand_items += cnt;
            settle();
        end

        $display("Streamed %0d source pixels and matched %0d averaged pixels", n_in, n_out);
        $display("over %0d geometry/channel settings, %0d errors", n_phases, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
